>>> sv/radix_digit_emitter_assert.svh
// Assertion macros shared by the radix digit emitter modules.
`ifndef RADIX_DIGIT_EMITTER_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define RDE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/rde_pkg.sv
// Types, constants and the digit encoder of the radix digit emitter.
`default_nettype none

package rde_pkg;

	localparam int unsigned VALUE_W = 63;
	localparam int unsigned BASE_W  = 5;
	localparam int unsigned CHAR_W  = 7;

	localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 5'd17;
	localparam logic [BASE_W-1:0] DEC_DIGITS = 5'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_G    = 7'h47;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [BASE_W-1:0]  base;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              last;
	} digit_t;

	// Commands from the sequencer to the divide unit
	typedef struct packed {
		logic load;
		logic step;
		logic next;
	} div_cmd_t;

	// Status from the divide unit back to the sequencer
	typedef struct packed {
		logic              last_step;
		logic              quo_zero;
		logic [BASE_W-1:0] rem;
	} div_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Map a remainder to its ASCII digit, '0'..'9' then 'A'..'G'
	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [BASE_W-1:0] r);
		logic [CHAR_W-1:0] c;
		if (r < DEC_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(r);
		end else begin
			c = CHAR_A + CHAR_W'(r - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> sv/radix_digit_emitter.sv
// Top level of the radix digit emitter: sequencer, divide unit and output register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------
//  item    | in        | item_valid / item_ready    | item.value, item.base
//  digit   | out       | digit_valid / digit_ready  | digit.digit_char, digit.last
//
// Each digit is one division followed by an emit step: the first division runs over
// VALUE_BITS bits and each following one over one bit fewer, all through the single
// shared compare-subtract unit. item_ready is high only while the sequencer is idle;
// a full output register stalls the sequencer before it loads the next digit. Reset
// clears the control state only.
`default_nettype none

module radix_digit_emitter #(
	parameter int unsigned VALUE_BITS = 63
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire rde_pkg::item_t item,
	output logic                digit_valid,
	input  wire logic           digit_ready,
	output rde_pkg::digit_t     digit
);
	import rde_pkg::*;

	`include "radix_digit_emitter_assert.svh"

	state_t    state_q;
	state_t    state_nxt;
	div_cmd_t  cmd;
	div_stat_t stat;
	logic      slot_free;
	logic      out_load;
	logic      digit_valid_q;
	digit_t    digit_q;
	logic      char_ok;
	logic      owed;
	logic      more_digits;

	rde_div_unit #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.item  (item),
		.stat  (stat)
	);

	assign slot_free = !digit_valid_q || digit_ready;

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and divide unit commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (stat.last_step) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold the digit until the output register frees up
				if (slot_free) begin
					out_load = 1'b1;
					if (stat.quo_zero) begin
						state_nxt = ST_IDLE;
					end else begin
						cmd.next  = 1'b1;
						state_nxt = ST_DIV;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Output register: set on load, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_valid_q <= 1'b0;
		end else if (out_load) begin
			digit_valid_q <= 1'b1;
		end else if (digit_ready) begin
			digit_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digit_q.digit_char <= digit_to_char(stat.rem);
			digit_q.last       <= stat.quo_zero;
		end
	end

	assign digit_valid = digit_valid_q;
	assign digit       = digit_q;

	// Terms watched by the checks below
	assign char_ok     = (digit_q.digit_char >= CHAR_ZERO) && (digit_q.digit_char <= CHAR_G);
	assign owed        = digit_valid_q && !digit_q.last;
	assign more_digits = out_load && !stat.quo_zero;

	`RDE_ASSERT_NOW(a_char_range, digit_valid_q, char_ok, "digit character out of range")
	`RDE_ASSERT_NOW(a_more_pending, owed, state_q != ST_IDLE, "idle with digits still owed")
	`RDE_ASSERT_NEXT(a_next_digit, more_digits, state_q == ST_DIV, "division skipped")

endmodule

`default_nettype wire

>>> sv/rde_div_unit.sv
// Bit-serial restoring divider: one quotient bit per cycle while stepping, quotient kept in place.
`default_nettype none

module rde_div_unit #(
	parameter int unsigned VALUE_BITS = 63
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rde_pkg::div_cmd_t cmd,
	input  wire rde_pkg::item_t    item,
	output rde_pkg::div_stat_t     stat
);
	import rde_pkg::*;

	`include "radix_digit_emitter_assert.svh"

	localparam int unsigned IDX_W = $clog2(VALUE_BITS);

	logic [VALUE_BITS-1:0] work_q;
	logic [BASE_W-1:0]     rem_q;
	logic [BASE_W-1:0]     base_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      top_q;

	logic [BASE_W:0]   trial;
	logic [BASE_W:0]   diff;
	logic              ge;
	logic [BASE_W-1:0] base_clamped;

	// Clamp the incoming radix into the supported range
	always_comb begin
		if (item.base < BASE_MIN) begin
			base_clamped = BASE_MIN;
		end else if (item.base > BASE_MAX) begin
			base_clamped = BASE_MAX;
		end else begin
			base_clamped = item.base;
		end
	end

	// Shared compare-subtract on the partial remainder
	assign trial = {rem_q, work_q[idx_q]};
	assign ge    = (trial >= {1'b0, base_q});
	assign diff  = trial - {1'b0, base_q};

	// Quotient bits overwrite the dividend bits already consumed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= item.value[VALUE_BITS-1:0];
		end else if (cmd.step) begin
			work_q[idx_q] <= ge;
		end
	end

	// Remainder, radix and bit pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			base_q <= BASE_MIN;
			idx_q  <= '0;
			top_q  <= '0;
		end else if (cmd.load) begin
			rem_q  <= '0;
			base_q <= base_clamped;
			idx_q  <= IDX_W'(VALUE_BITS - 1);
			top_q  <= IDX_W'(VALUE_BITS - 1);
		end else if (cmd.next) begin
			// the quotient is at least one bit shorter than its dividend
			rem_q <= '0;
			idx_q <= top_q - 1'b1;
			top_q <= top_q - 1'b1;
		end else if (cmd.step) begin
			rem_q <= ge ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
			if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	assign stat.last_step = (idx_q == '0);
	assign stat.quo_zero  = (work_q == '0);
	assign stat.rem       = rem_q;

	`RDE_ASSERT_NOW(a_rem_below_base, 1'b1, rem_q < base_q, "remainder not below radix")
	`RDE_ASSERT_NOW(a_idx_in_window, 1'b1, idx_q <= top_q, "bit pointer above window")
	`RDE_ASSERT_NEXT(a_base_clamped, cmd.load, (base_q >= BASE_MIN) && (base_q <= BASE_MAX), "radix out of range")

endmodule

`default_nettype wire
